### rtl/tic_pkg.sv
// ----------------------------------------------------------------------------
// tic_pkg
// Shared types and constants of the thresholded intensity centroid core.
// ----------------------------------------------------------------------------
package tic_pkg;

    localparam int DEF_MAX_WIDTH     = 4096;
    localparam int DEF_MAX_HEIGHT    = 4096;
    localparam int DEF_FRACTION_BITS = 4;

    localparam int PIXEL_W    = 8;
    localparam int FRAME_W_W  = 13;
    localparam int CENTROID_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [PIXEL_W-1:0]   THRESHOLD_RESET   = 8'd150;
    localparam logic [FRAME_W_W-1:0] FRAME_WIDTH_RESET = 13'd640;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 2'd1;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               frame_end;
    } pixel_beat_t;

    typedef struct packed {
        logic [CENTROID_W-1:0] centroid_x;
        logic [CENTROID_W-1:0] centroid_y;
        logic                  marker_found;
    } result_beat_t;

endpackage

### rtl/tic_fifo.sv
// ----------------------------------------------------------------------------
// tic_fifo
// Two-entry queue that carries finished frame sums from front to back.
// ----------------------------------------------------------------------------
module tic_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### rtl/tic_front.sv
// ----------------------------------------------------------------------------
// tic_front
// Pixel intake: threshold, position tracking and weighted accumulation.
// ----------------------------------------------------------------------------
module tic_front #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    parameter int IW         = 33,
    parameter int SW         = 45
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  tic_pkg::pixel_beat_t        sample,
    input  logic [tic_pkg::PIXEL_W-1:0] threshold,
    input  logic [tic_pkg::FRAME_W_W-1:0] frame_width,
    output logic                        q_push,
    input  logic                        q_full,
    output logic [2*SW+IW-1:0]          q_data
);

    import tic_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int EW  = FRAME_W_W + 1;
    localparam logic [EW-1:0] MAXW_E = EW'(MAX_WIDTH);
    localparam logic [RW-1:0] ROW_TOP = RW'(MAX_HEIGHT - 1);

    logic [CW-1:0]      col_reg;
    logic [CW-1:0]      col_next;
    logic [RW-1:0]      row_reg;
    logic [RW-1:0]      row_next;

    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic               s1_last_reg;
    logic [PIXEL_W-1:0] s1_inten_reg;
    logic [CW-1:0]      s1_col_reg;
    logic [RW-1:0]      s1_row_reg;

    logic [IW-1:0]      isum_reg;
    logic [IW-1:0]      isum_next;
    logic [SW-1:0]      xsum_reg;
    logic [SW-1:0]      xsum_next;
    logic [SW-1:0]      ysum_reg;
    logic [SW-1:0]      ysum_next;

    logic               accept;
    logic               advance;
    logic [EW-1:0]      fw_ext;
    logic [EW-1:0]      width_eff;
    logic [CW:0]        col_inc;
    logic [CW+7:0]      xprod;
    logic [RW+7:0]      yprod;
    logic [IW-1:0]      isum_acc;
    logic [SW-1:0]      xsum_acc;
    logic [SW-1:0]      ysum_acc;

    // Stall only while a frame end waits for room in the queue
    assign full    = s1_valid_reg & s1_last_reg & q_full;
    assign accept  = push & ~full;
    assign advance = s1_valid_reg & (~s1_last_reg | ~q_full);

    assign fw_ext  = {1'b0, frame_width};
    assign col_inc = {1'b0, col_reg} + {{CW{1'b0}}, 1'b1};

    always_comb
    begin
        if (fw_ext == '0)
        begin
            width_eff = EW'(1);
        end
        else if (fw_ext > MAXW_E)
        begin
            width_eff = MAXW_E;
        end
        else
        begin
            width_eff = fw_ext;
        end

        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (sample.frame_end)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (EW'(col_inc) >= width_eff)
            begin
                col_next = '0;
                if (row_reg != ROW_TOP)
                begin
                    row_next = row_reg + RW'(1);
                end
            end
            else
            begin
                col_next = col_inc[CW-1:0];
            end
        end
    end

    assign s1_valid_next = accept | (s1_valid_reg & ~advance);

    assign xprod    = (CW+8)'(s1_col_reg) * (CW+8)'(s1_inten_reg);
    assign yprod    = (RW+8)'(s1_row_reg) * (RW+8)'(s1_inten_reg);
    assign isum_acc = isum_reg + IW'(s1_inten_reg);
    assign xsum_acc = xsum_reg + SW'(xprod);
    assign ysum_acc = ysum_reg + SW'(yprod);

    assign q_push = advance & s1_last_reg;
    assign q_data = {xsum_acc, ysum_acc, isum_acc};

    always_comb
    begin
        isum_next = isum_reg;
        xsum_next = xsum_reg;
        ysum_next = ysum_reg;
        if (advance)
        begin
            if (s1_last_reg)
            begin
                isum_next = '0;
                xsum_next = '0;
                ysum_next = '0;
            end
            else
            begin
                isum_next = isum_acc;
                xsum_next = xsum_acc;
                ysum_next = ysum_acc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            isum_reg     <= '0;
            xsum_reg     <= '0;
            ysum_reg     <= '0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= s1_valid_next;
            isum_reg     <= isum_next;
            xsum_reg     <= xsum_next;
            ysum_reg     <= ysum_next;
        end
    end

    // Capture the thresholded pixel and its position
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_last_reg  <= sample.frame_end;
            s1_inten_reg <= (sample.pixel > threshold) ? sample.pixel : '0;
            s1_col_reg   <= col_reg;
            s1_row_reg   <= row_reg;
        end
    end

endmodule

### rtl/tic_divider.sv
// ----------------------------------------------------------------------------
// tic_divider
// Back end: two restoring dividers, one quotient bit per cycle, result slot.
// ----------------------------------------------------------------------------
module tic_divider #(
    parameter int IW = 33,
    parameter int SW = 45,
    parameter int QW = 16,
    parameter int FRACTION_BITS = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_empty,
    output logic                  q_pop,
    input  logic [2*SW+IW-1:0]    q_data,
    output logic                  empty,
    input  logic                  pop,
    output tic_pkg::result_beat_t result
);

    import tic_pkg::*;

    localparam int NW  = SW + FRACTION_BITS;
    localparam int SCW = $clog2(QW + 1);
    localparam int QXW = (QW > CENTROID_W) ? QW : CENTROID_W;
    localparam logic [QXW-1:0] OUT_MAX = QXW'({CENTROID_W{1'b1}});

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DIV  = 2'b10
    } div_state_t;

    div_state_t     state_reg;
    div_state_t     state_next;
    logic [SCW-1:0] step_reg;
    logic [SCW-1:0] step_next;
    logic           res_valid_reg;
    logic           res_valid_next;
    result_beat_t   result_reg;

    logic [IW-1:0]  den_reg;
    logic           found_reg;
    logic [IW-1:0]  xrem_reg;
    logic [IW-1:0]  yrem_reg;
    logic [QW-1:0]  xq_reg;
    logic [QW-1:0]  yq_reg;

    logic [SW-1:0]  in_xsum;
    logic [SW-1:0]  in_ysum;
    logic [IW-1:0]  in_isum;
    logic [NW-1:0]  xnum;
    logic [NW-1:0]  ynum;
    logic [IW:0]    xtrial;
    logic [IW:0]    ytrial;
    logic [IW:0]    xdiff;
    logic [IW:0]    ydiff;
    logic           xge;
    logic           yge;
    logic           load;
    logic           iterate;
    logic           finish;
    logic           out_pop;
    logic [QXW-1:0] xq_ext;
    logic [QXW-1:0] yq_ext;

    assign {in_xsum, in_ysum, in_isum} = q_data;
    assign xnum = NW'(in_xsum) << FRACTION_BITS;
    assign ynum = NW'(in_ysum) << FRACTION_BITS;

    assign out_pop = pop & res_valid_reg;
    assign empty   = ~res_valid_reg;
    assign result  = result_reg;

    assign xtrial = {xrem_reg, xq_reg[QW-1]};
    assign ytrial = {yrem_reg, yq_reg[QW-1]};
    assign xdiff  = xtrial - {1'b0, den_reg};
    assign ydiff  = ytrial - {1'b0, den_reg};
    assign xge    = (xtrial >= {1'b0, den_reg});
    assign yge    = (ytrial >= {1'b0, den_reg});

    assign xq_ext = QXW'(xq_reg);
    assign yq_ext = QXW'(yq_reg);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        load       = 1'b0;
        iterate    = 1'b0;
        finish     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    load       = 1'b1;
                    step_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (step_reg != SCW'(QW))
                begin
                    iterate   = 1'b1;
                    step_next = step_reg + SCW'(1);
                end
                else if (!res_valid_reg || out_pop)
                begin
                    finish     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        res_valid_next = finish ? 1'b1 : (out_pop ? 1'b0 : res_valid_reg);
    end

    assign q_pop = load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Shift the dividend low bits out while quotient bits shift in behind them
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            den_reg   <= in_isum;
            found_reg <= (in_isum != '0);
            xrem_reg  <= xnum[NW-1:QW];
            yrem_reg  <= ynum[NW-1:QW];
            xq_reg    <= xnum[QW-1:0];
            yq_reg    <= ynum[QW-1:0];
        end
        else if (iterate)
        begin
            xrem_reg <= xge ? xdiff[IW-1:0] : xtrial[IW-1:0];
            yrem_reg <= yge ? ydiff[IW-1:0] : ytrial[IW-1:0];
            xq_reg   <= (xq_reg << 1) | QW'(xge);
            yq_reg   <= (yq_reg << 1) | QW'(yge);
        end

        if (finish)
        begin
            result_reg.marker_found <= found_reg;
            if (!found_reg)
            begin
                result_reg.centroid_x <= '0;
                result_reg.centroid_y <= '0;
            end
            else
            begin
                result_reg.centroid_x <= (xq_ext > OUT_MAX) ? '1 : xq_ext[CENTROID_W-1:0];
                result_reg.centroid_y <= (yq_ext > OUT_MAX) ? '1 : yq_ext[CENTROID_W-1:0];
            end
        end
    end

endmodule

### rtl/thresholded_intensity_centroid_core.sv
// ----------------------------------------------------------------------------
// thresholded_intensity_centroid_core
// Intensity-weighted centroid of the above-threshold pixels of each frame.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter in raster order on the push/full side, one beat per clock
//   while full is low; frame_end marks the last pixel of a frame. Column and
//   row are tracked inside from the frame_width register.
//   One result beat per frame leaves on the empty/pop side: centroid x and y
//   in unsigned fixed point with FRACTION_BITS fraction bits, truncated and
//   saturated to 16 bits, plus marker_found. An empty frame gives 0,0 and
//   marker_found low.
//   Throughput: one pixel per cycle while full is low. Each frame end
//   starts a division over QW quotient bits, with
//   QW = clog2(max(MAX_WIDTH, MAX_HEIGHT)) + FRACTION_BITS; frame sums queue
//   two deep, so only frames shorter than a division back up into full.
//   Path: the frame-end beat is registered in the front, its sums pass the
//   queue, and the divider loads, iterates and registers the result beat.
//   Stall: while pop is held low the result waits; the next frame's division
//   finishes and holds, then the sum queue fills and full rises on the next
//   frame-end beat. No beat is dropped.
//   Reset: threshold 150, frame width 640, position and sums cleared.
//   Configuration writes (cfg_valid, always ready) belong in idle time.
// ----------------------------------------------------------------------------
module thresholded_intensity_centroid_core #(
    parameter int MAX_WIDTH     = tic_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT    = tic_pkg::DEF_MAX_HEIGHT,
    parameter int FRACTION_BITS = tic_pkg::DEF_FRACTION_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  tic_pkg::pixel_beat_t           sample,
    output logic                           empty,
    input  logic                           pop,
    output tic_pkg::result_beat_t          result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tic_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tic_pkg::CFG_DATA_W-1:0] cfg_data
);

    import tic_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int PW = (CW > RW) ? CW : RW;
    // Intensity sum covers a full frame with a spare bit; weighted sums add
    // the widest position
    localparam int IW = PIXEL_W + CW + RW + 1;
    localparam int SW = IW + PW;
    localparam int QW = PW + FRACTION_BITS;
    localparam int DW = 2 * SW + IW;

    logic [PIXEL_W-1:0]   threshold_reg;
    logic [FRAME_W_W-1:0] frame_width_reg;
    logic                 cfg_write;

    logic                 fq_push;
    logic                 fq_full;
    logic [DW-1:0]        fq_wdata;
    logic                 fq_pop;
    logic [DW-1:0]        fq_rdata;
    logic                 fq_empty;

    // Register writes are never stalled: ready is tied high
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid & cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg   <= THRESHOLD_RESET;
            frame_width_reg <= FRAME_WIDTH_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_THRESHOLD)
            begin
                threshold_reg <= cfg_data[PIXEL_W-1:0];
            end
            else if (cfg_index == REG_FRAME_WIDTH)
            begin
                frame_width_reg <= cfg_data[FRAME_W_W-1:0];
            end
        end
    end

    // Front: threshold, track position, accumulate; hand frame sums over
    tic_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .IW         (IW),
        .SW         (SW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .sample      (sample),
        .threshold   (threshold_reg),
        .frame_width (frame_width_reg),
        .q_push      (fq_push),
        .q_full      (fq_full),
        .q_data      (fq_wdata)
    );

    // Frame sums wait here so pixel intake and division stall independently
    tic_fifo #(
        .WIDTH (DW)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (fq_push),
        .wr_data (fq_wdata),
        .full    (fq_full),
        .pop     (fq_pop),
        .rd_data (fq_rdata),
        .empty   (fq_empty)
    );

    // Back: divide both weighted sums by the intensity sum, hold the result
    tic_divider #(
        .IW            (IW),
        .SW            (SW),
        .QW            (QW),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_divider (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (fq_empty),
        .q_pop   (fq_pop),
        .q_data  (fq_rdata),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

### test/thresholded_intensity_centroid_core_tb.sv
// ----------------------------------------------------------------------------
// thresholded_intensity_centroid_core_tb
// Self-checking bench for the thresholded intensity centroid core.
// ----------------------------------------------------------------------------
// Pixel beats go in through the push/full side and result beats come out on
// the empty/pop side. A scoreboard object keeps its own copy of the frame
// position, the running sums and both registers. It works out the centroid
// beat that each frame-end pixel should produce and checks every popped beat
// against the oldest one still waiting.
//
// The run has three parts:
//   - short hand-written frames for the threshold edge, empty frames,
//     zero frame width and the register extremes;
//   - short frames at a width above the widest row and at the widest row,
//     where the width clamps;
//   - random phases, most with new register values, a mix of dark, sparse
//     and noisy frames, and random gaps on both sides unless steady. The
//     first phase holds off pop for a long stretch so that the core backs up into full.
// ----------------------------------------------------------------------------
module thresholded_intensity_centroid_core_tb;

    import tic_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 40;     // well past the result latency
    localparam int HOLD_CYCLES   = 400;    // long pop hold-off for back-pressure
    localparam int RANDOM_PIXELS = 950;

    typedef enum int
    {
        STYLE_DARK,     // nothing above threshold: empty frame
        STYLE_MIXED,    // noise over the full range, some values at the threshold
        STYLE_SPARSE,   // a few bright pixels scattered over a dark frame
        STYLE_EDGES     // bright only at the first pixel and the last few
    } frame_style_t;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks position and sums per frame, queues the expected
    // centroid beats and compares popped beats against them.
    // ------------------------------------------------------------------------
    class centroid_scoreboard;
        logic [PIXEL_W-1:0]   threshold;
        logic [FRAME_W_W-1:0] frame_width;
        logic [11:0]          column;
        logic [11:0]          row;
        logic [32:0]          intensity_sum;
        logic [44:0]          x_sum;
        logic [44:0]          y_sum;
        result_beat_t         centroid_q[$];
        int unsigned          errors;

        function new();
            threshold   = THRESHOLD_RESET;
            frame_width = FRAME_WIDTH_RESET;
            errors      = 0;
            restart_frame();
        endfunction

        function void restart_frame();
            column        = '0;
            row           = '0;
            intensity_sum = '0;
            x_sum         = '0;
            y_sum         = '0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] index,
                                     logic [CFG_DATA_W-1:0] data);
            case (index)
                REG_THRESHOLD:   threshold   = data[PIXEL_W-1:0];
                REG_FRAME_WIDTH: frame_width = data[FRAME_W_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [CENTROID_W-1:0] fixed_ratio(logic [44:0] num, logic [32:0] den);
            logic [63:0] q;
            q = (64'(num) << DEF_FRACTION_BITS) / 64'(den);
            return (q > 64'hFFFF) ? 16'hFFFF : q[CENTROID_W-1:0];
        endfunction

        function void note_pixel(pixel_beat_t b);
            logic [FRAME_W_W-1:0] span;
            logic [PIXEL_W-1:0]   level;
            result_beat_t         r;
            // Zero width acts as one, anything past the widest row as the widest.
            if (frame_width == 0)
                span = 13'd1;
            else if (frame_width > 13'(DEF_MAX_WIDTH))
                span = 13'(DEF_MAX_WIDTH);
            else
                span = frame_width;
            level = (b.pixel > threshold) ? b.pixel : '0;

            intensity_sum += 33'(level);
            x_sum         += 45'(column) * 45'(level);
            y_sum         += 45'(row) * 45'(level);

            if (b.frame_end)
            begin
                if (intensity_sum != 0)
                begin
                    r.centroid_x   = fixed_ratio(x_sum, intensity_sum);
                    r.centroid_y   = fixed_ratio(y_sum, intensity_sum);
                    r.marker_found = 1'b1;
                end
                else
                begin
                    r = '0;
                end
                centroid_q.push_back(r);
                restart_frame();
            end
            else if (13'(column) + 13'd1 >= span)
            begin
                column = '0;
                if (row < 12'(DEF_MAX_HEIGHT - 1))
                    row++;
            end
            else
            begin
                column++;
            end
        endfunction

        function void check_result(result_beat_t got);
            result_beat_t exp_beat;
            if (centroid_q.size() == 0)
            begin
                $error("unexpected result beat: x %0d y %0d found %0b",
                       got.centroid_x, got.centroid_y, got.marker_found);
                errors++;
                return;
            end
            exp_beat = centroid_q.pop_front();
            if (got.centroid_x !== exp_beat.centroid_x)
            begin
                $error("centroid_x: expected %0d, actual %0d",
                       exp_beat.centroid_x, got.centroid_x);
                errors++;
            end
            if (got.centroid_y !== exp_beat.centroid_y)
            begin
                $error("centroid_y: expected %0d, actual %0d",
                       exp_beat.centroid_y, got.centroid_y);
                errors++;
            end
            if (got.marker_found !== exp_beat.marker_found)
            begin
                $error("marker_found: expected %0b, actual %0b",
                       exp_beat.marker_found, got.marker_found);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic                  clk;
    logic                  rst_n;
    logic                  push;
    logic                  full;
    pixel_beat_t           pixel_in;
    logic                  empty;
    logic                  pop;
    result_beat_t          result_out;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    centroid_scoreboard sb;
    bit                 steady;         // suppress idle gaps on both sides
    bit                 hold_results;   // ask the pop side for a long hold-off
    int unsigned        pixels_sent;

    thresholded_intensity_centroid_core u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .sample    (pixel_in),
        .empty     (empty),
        .pop       (pop),
        .result    (result_out),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned idle_gap();
        int unsigned r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: sample every handshake at the rising edge and feed the
    // scoreboard. Register writes first, then input beats, then results.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_register(cfg_index, cfg_data);
            if (push && !full)
                sb.note_pixel(pixel_in);
            if (pop && !empty)
                sb.check_result(result_out);
        end
    end

    // ------------------------------------------------------------------------
    // Pop side: random stalls, plus one long hold-off on request. The hold is
    // counted here so it ends on its own while the push side keeps offering.
    // ------------------------------------------------------------------------
    initial
    begin : pop_side
        int unsigned stall;
        pop   = 1'b0;
        stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_results)
            begin
                hold_results = 1'b0;
                stall        = HOLD_CYCLES;
                pop <= 1'b0;
            end
            else if (stall > 0)
            begin
                stall--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
                stall = idle_gap();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Push side tasks
    // ------------------------------------------------------------------------

    // Offer one pixel beat after a random gap; hold it until full drops.
    task automatic send_pixel(input logic [PIXEL_W-1:0] pix, input logic last);
        int unsigned gap;
        gap = idle_gap();
        repeat (gap)
        begin
            @(negedge clk);
            push <= 1'b0;
        end
        @(negedge clk);
        push               <= 1'b1;
        pixel_in.pixel     <= pix;
        pixel_in.frame_end <= last;
        forever
        begin
            @(posedge clk);
            if (!full)
                break;
        end
        pixels_sent++;
    endtask

    function automatic logic [PIXEL_W-1:0] pick_pixel(frame_style_t style, int unsigned thr,
                                                      int unsigned idx, int unsigned len);
        int unsigned dark;
        int unsigned bright;
        dark   = $urandom_range(0, thr);
        bright = (thr >= 255) ? 255 : $urandom_range(thr + 1, 255);
        case (style)
            STYLE_DARK:   return PIXEL_W'(dark);
            STYLE_SPARSE: return PIXEL_W'(($urandom_range(0, 9) == 0) ? bright : dark);
            STYLE_EDGES:  return PIXEL_W'((idx == 0 || idx + 8 >= len) ? bright : dark);
            default:
            begin
                // Land right on the threshold now and then.
                case ($urandom_range(0, 9))
                    0:       return PIXEL_W'(thr);
                    1:       return PIXEL_W'((thr < 255) ? thr + 1 : 255);
                    default: return PIXEL_W'($urandom_range(0, 255));
                endcase
            end
        endcase
    endfunction

    task automatic send_frame(input int unsigned len, input frame_style_t style);
        int unsigned i;
        int unsigned thr;
        thr = 32'(sb.threshold);
        for (i = 0; i < len; i++)
            send_pixel(pick_pixel(style, thr, i, len), i == len - 1);
    endtask

    // Drop push, wait until every centroid beat is back, then let the
    // divider pipeline settle before anything touches the registers.
    task automatic wait_idle();
        @(negedge clk);
        push <= 1'b0;
        while (sb.centroid_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write either or both registers back to back, then drop valid.
    task automatic configure(input bit set_thr, input logic [PIXEL_W-1:0] thr,
                             input bit set_width, input logic [FRAME_W_W-1:0] width);
        if (set_thr)
        begin
            @(negedge clk);
            cfg_valid <= 1'b1;
            cfg_index <= REG_THRESHOLD;
            cfg_data  <= CFG_DATA_W'(thr);
            forever
            begin
                @(posedge clk);
                if (cfg_ready)
                    break;
            end
        end
        if (set_width)
        begin
            @(negedge clk);
            cfg_valid <= 1'b1;
            cfg_index <= REG_FRAME_WIDTH;
            cfg_data  <= CFG_DATA_W'(width);
            forever
            begin
                @(posedge clk);
                if (cfg_ready)
                    break;
            end
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [PIXEL_W-1:0] pick_threshold();
        case ($urandom_range(0, 6))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return PIXEL_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly narrow rows so frames span several of them; the extremes too.
    function automatic logic [FRAME_W_W-1:0] pick_width();
        case ($urandom_range(0, 19))
            0:       return 13'd0;
            1:       return 13'd1;
            2:       return 13'd4096;
            3:       return 13'd8191;
            4:       return 13'd640;
            5, 6, 7: return FRAME_W_W'($urandom_range(17, 64));
            default: return FRAME_W_W'($urandom_range(1, 16));
        endcase
    endfunction

    function automatic int unsigned pick_frame_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return $urandom_range(1, 3);
        if (r < 85)
            return $urandom_range(4, 30);
        return $urandom_range(31, 120);
    endfunction

    function automatic frame_style_t pick_style();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return STYLE_DARK;
        if (r < 60)
            return STYLE_MIXED;
        return STYLE_SPARSE;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned start_count;
        int unsigned n_frames;
        int unsigned k;

        sb           = new();
        rst_n        = 1'b0;
        push         = 1'b0;
        pixel_in     = '0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_THRESHOLD;
        cfg_data     = '0;
        steady       = 1'b0;
        hold_results = 1'b0;
        pixels_sent  = 0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Reset values: threshold 150, width 640.
        send_pixel(8'd255, 1'b1);           // single bright pixel at the origin
        send_pixel(8'd150, 1'b1);           // equal to threshold: empty frame
        send_pixel(8'd151, 1'b0);           // just above threshold
        send_pixel(8'd0,   1'b0);
        send_pixel(8'd200, 1'b1);

        // Threshold 0: any nonzero pixel counts. Two-pixel rows.
        wait_idle();
        configure(1'b1, 8'd0, 1'b1, 13'd2);
        send_pixel(8'd1,   1'b0);
        send_pixel(8'd0,   1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd128, 1'b0);
        send_pixel(8'd7,   1'b0);
        send_pixel(8'd255, 1'b1);

        // Threshold 255 makes every frame empty; width 0 acts as one column.
        wait_idle();
        configure(1'b1, 8'd255, 1'b1, 13'd0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd254, 1'b0);
        send_pixel(8'd255, 1'b1);

        // Width 0 again with a live threshold: one pixel per row.
        wait_idle();
        configure(1'b1, 8'd254, 1'b0, '0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd0,   1'b0);
        send_pixel(8'd255, 1'b1);

        // Width above the maximum clamps to it; then exactly the maximum.
        wait_idle();
        configure(1'b1, 8'd0, 1'b1, 13'd8191);
        send_frame(24, STYLE_EDGES);

        wait_idle();
        configure(1'b0, '0, 1'b1, 13'd4096);
        send_frame(24, STYLE_EDGES);

        // Back-pressure: hold off pop while a run of tiny frames keeps coming,
        // so the sum queue fills and full rises.
        wait_idle();
        steady = 1'b0;
        configure(1'b1, 8'd20, 1'b1, 13'd3);
        start_count  = pixels_sent;
        hold_results = 1'b1;
        repeat (2) @(negedge clk);
        for (k = 0; k < 30; k++)
            send_frame($urandom_range(1, 3), STYLE_MIXED);

        // Random phases until enough pixel beats have gone in.
        while (pixels_sent - start_count < RANDOM_PIXELS)
        begin
            wait_idle();
            configure($urandom_range(0, 9) < 7, pick_threshold(),
                      $urandom_range(0, 9) < 7, pick_width());
            steady   = ($urandom_range(0, 3) == 0);
            n_frames = $urandom_range(3, 8);
            for (k = 0; k < n_frames; k++)
                send_frame(pick_frame_len(), pick_style());
        end

        wait_idle();
        if (sb.errors == 0 && sb.centroid_q.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #60000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
